// ===== design/wrs_pkg.sv =====
// wrs_pkg: shared types and constants of the weighted reaction selector.
// Transaction payload structs, status and operation codes, controller states.
// No dependencies.
package wrs_pkg;

    localparam int RATE_W   = 32;   // rate entry, unsigned Q16.16
    localparam int PREFIX_W = 36;   // prefix sum, unsigned Q20.16
    localparam int CNT_W    = 5;    // reactions_in_use register
    localparam int IDX_W    = 4;    // reaction index field

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd1;

    // configuration register word indexes
    localparam logic REG_REACTIONS_IN_USE = 1'b0;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_DRAW  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_BEYOND  = 2'd1,
        STATUS_WRITTEN = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                 operation;
        logic [IDX_W-1:0]    reaction_index;
        logic [RATE_W-1:0]   rate_value;
        logic [PREFIX_W-1:0] draw_point;
    } cmd_t;

    typedef struct packed
    {
        logic [IDX_W-1:0]    chosen_reaction;
        logic [PREFIX_W-1:0] total_rate;
        status_t             status;
    } result_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOAD,
        S_REBUILD,
        S_FETCH,
        S_WR_END,
        S_DRAW_TOT,
        S_SEARCH
    } state_t;

endpackage

// ===== design/wrs_table.sv =====
// wrs_table: single-port-write, single-port-read synchronous table with registered
// read data, and per-entry valid bits so unwritten entries read as zero.
// Depends on nothing.
module wrs_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

    // controller never reads an entry in the cycle it writes it
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re && (waddr == raddr)))
        else $error("wrs_table: read and write of the same entry");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (32'(waddr) < DEPTH))
        else $error("wrs_table: write beyond depth");

    a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        re |-> (32'(raddr) < DEPTH))
        else $error("wrs_table: read beyond depth");

endmodule

// ===== design/weighted_reaction_selector.sv =====
// weighted_reaction_selector: rate table, prefix-sum table and binary-search
// selection of a reaction for a point on the cumulative rate axis.
// Depends on wrs_pkg and wrs_table.
//
//  channel   | signals                              | transaction taken when
//  ----------+--------------------------------------+--------------------------------
//  command   | start, busy, cmd (cmd_t)             | start high and busy low
//  result    | done, result (result_t)              | done high, one cycle, no stall
//  config    | psel penable pwrite paddr pwdata     | psel, penable, pwrite, pready
//            | prdata pready (always high)          |   all high (word 0 only)
//
// A rate write runs the prefix rebuild, which walks one rate entry per cycle from
// the written index to the end of the table; an out-of-range write skips it. A
// draw reads the total and, for a point inside it, binary-searches the prefix
// table, one prefix-table read per step. done comes the cycle after the last busy
// cycle, and a new command may be taken in that same cycle. Reset sets the
// register to one and clears all table valid bits.
module weighted_reaction_selector import wrs_pkg::*; #(
    parameter int MAX_REACTIONS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // command
    input  logic         start,
    input  cmd_t         cmd,
    output logic         busy,
    // result
    output logic         done,
    output result_t      result
);

    localparam int RW = $clog2(MAX_REACTIONS);       // rate table address
    localparam int CW = $clog2(MAX_REACTIONS + 1);   // prefix table address / count

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] cfg_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_REACTIONS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CNT_RESET;
        end
        else if (cfg_wr)
        begin
            cfg_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_REACTIONS_IN_USE) ? {{(32-CNT_W){1'b0}}, cfg_reg} : '0;

    // active count, clamped to the table size
    logic [CW-1:0] n_act;
    assign n_act = (32'(cfg_reg) > MAX_REACTIONS) ? CW'(MAX_REACTIONS) : CW'(cfg_reg);

    // ------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------
    logic                rate_we, rate_re;
    logic [RW-1:0]       rate_waddr, rate_raddr;
    logic [RATE_W-1:0]   rate_wdata, rate_rdata;
    logic                cum_we, cum_re;
    logic [CW-1:0]       cum_waddr, cum_raddr;
    logic [PREFIX_W-1:0] cum_wdata, cum_rdata;

    wrs_table #(.DEPTH(MAX_REACTIONS), .WIDTH(RATE_W)) u_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rate_we),
        .waddr (rate_waddr),
        .wdata (rate_wdata),
        .re    (rate_re),
        .raddr (rate_raddr),
        .rdata (rate_rdata)
    );

    // entry k = sum of rates 0..k-1; entry 0 is never written and reads zero
    wrs_table #(.DEPTH(MAX_REACTIONS + 1), .WIDTH(PREFIX_W)) u_cum (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cum_we),
        .waddr (cum_waddr),
        .wdata (cum_wdata),
        .re    (cum_re),
        .raddr (cum_raddr),
        .rdata (cum_rdata)
    );

    // ------------------------------------------------------------------
    // controller state and datapath registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [PREFIX_W-1:0] acc_reg, acc_next;       // running prefix in rebuild
    logic [RW-1:0]       k_reg, k_next;           // rate entry in rebuild
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [PREFIX_W-1:0] point_reg, point_next;
    logic [PREFIX_W-1:0] total_reg, total_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    logic accept;
    logic in_range;

    assign accept   = start && (state_reg == S_IDLE);
    assign in_range = 32'(cmd.reaction_index) < MAX_REACTIONS;
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign result   = result_reg;

    // ------------------------------------------------------------------
    // rebuild and search arithmetic
    // ------------------------------------------------------------------
    logic [CW-1:0]       k_inc;
    logic                k_last;
    logic [PREFIX_W:0]   sum_wide;
    logic [PREFIX_W-1:0] sum_sat;
    logic                flagged;
    logic                le;
    logic [CW-1:0]       step_lo, step_hi, step_mid;
    logic [CW:0]         mid_wide;
    logic                step_more;

    always_comb
    begin
        k_inc    = CW'(k_reg) + CW'(1);
        k_last   = (k_reg == RW'(MAX_REACTIONS - 1));
        sum_wide = {1'b0, acc_reg} + (PREFIX_W + 1)'(rate_rdata);
        sum_sat  = sum_wide[PREFIX_W] ? '1 : sum_wide[PREFIX_W-1:0];

        flagged  = (n_act == '0) || (point_reg >= cum_rdata);
        le       = (cum_rdata <= point_reg);

        if (state_reg == S_SEARCH)
        begin
            step_lo = le ? mid_reg : lo_reg;
            step_hi = le ? hi_reg : (mid_reg - CW'(1));
        end
        else
        begin
            step_lo = '0;
            step_hi = n_act - CW'(1);
        end
        mid_wide  = ({1'b0, step_lo} + {1'b0, step_hi} + (CW + 1)'(1)) >> 1;
        step_mid  = mid_wide[CW-1:0];
        step_more = (step_lo < step_hi);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation == OP_DRAW)
                    begin
                        state_next = S_DRAW_TOT;
                    end
                    else if (in_range)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_WR_END;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_REBUILD;
            end
            S_REBUILD:
            begin
                if (k_last)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_WR_END;
            end
            S_WR_END:
            begin
                state_next = S_IDLE;
            end
            S_DRAW_TOT:
            begin
                state_next = (!flagged && step_more) ? S_SEARCH : S_IDLE;
            end
            S_SEARCH:
            begin
                state_next = step_more ? S_SEARCH : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: table ports, datapath register loads, result
    // ------------------------------------------------------------------
    always_comb
    begin
        rate_we     = 1'b0;
        rate_waddr  = RW'(cmd.reaction_index);
        rate_wdata  = cmd.rate_value;
        rate_re     = 1'b0;
        rate_raddr  = k_reg;
        cum_we      = 1'b0;
        cum_waddr   = k_inc;
        cum_wdata   = sum_sat;
        cum_re      = 1'b0;
        cum_raddr   = n_act;
        acc_next    = acc_reg;
        k_next      = k_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        point_next  = point_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    point_next = cmd.draw_point;
                    cum_re     = 1'b1;
                    if (cmd.operation == OP_WRITE && in_range)
                    begin
                        rate_we   = 1'b1;
                        k_next    = RW'(cmd.reaction_index);
                        cum_raddr = CW'(cmd.reaction_index);
                    end
                end
            end
            S_LOAD:
            begin
                // prefix below the written entry is unchanged
                acc_next = cum_rdata;
                rate_re  = 1'b1;
            end
            S_REBUILD:
            begin
                cum_we     = 1'b1;
                acc_next   = sum_sat;
                k_next     = RW'(k_inc);
                rate_re    = !k_last;
                rate_raddr = RW'(k_inc);
            end
            S_FETCH:
            begin
                cum_re = 1'b1;
            end
            S_WR_END:
            begin
                done_next   = 1'b1;
                result_next = '{chosen_reaction: '0, total_rate: cum_rdata,
                                status: STATUS_WRITTEN};
            end
            S_DRAW_TOT:
            begin
                total_next = cum_rdata;
                lo_next    = step_lo;
                hi_next    = step_hi;
                mid_next   = step_mid;
                if (flagged)
                begin
                    done_next   = 1'b1;
                    result_next = '{chosen_reaction: '0, total_rate: cum_rdata,
                                    status: STATUS_BEYOND};
                end
                else if (step_more)
                begin
                    cum_re    = 1'b1;
                    cum_raddr = step_mid;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{chosen_reaction: '0, total_rate: cum_rdata,
                                    status: STATUS_OK};
                end
            end
            S_SEARCH:
            begin
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_mid;
                if (step_more)
                begin
                    cum_re    = 1'b1;
                    cum_raddr = step_mid;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{chosen_reaction: IDX_W'(step_lo), total_rate: total_reg,
                                    status: STATUS_OK};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        k_reg      <= k_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        point_reg  <= point_next;
        total_reg  <= total_next;
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    a_search_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg < hi_reg) && (mid_reg > lo_reg)
            && (mid_reg <= hi_reg))
        else $error("binary search interval broken");

    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_WRITTEN) |-> (result.chosen_reaction == '0))
        else $error("write result carries a reaction index");

    a_ok_nonzero_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_OK) |-> (result.total_rate != '0))
        else $error("draw accepted against an empty total");

endmodule

// ===== tb/weighted_reaction_selector_tb.sv =====
// weighted_reaction_selector_tb: self-checking testbench for the weighted reaction selector.
// Directed and random rate writes and draws are checked against an in-bench predictor.
// Depends on wrs_pkg and weighted_reaction_selector.
`timescale 1ns / 1ps

module weighted_reaction_selector_tb;
    import wrs_pkg::*;

    localparam int MAX_REACTIONS = 16;
    localparam int QUIET_LIMIT   = 5000;               // cycles with no activity before giving up
    localparam int SETTLE_CYCLES = MAX_REACTIONS + 8;  // longest rebuild plus margin
    localparam int PHASE_ITEMS   = 170;

    localparam logic [PREFIX_W:0] PREFIX_MAX = {1'b0, {PREFIX_W{1'b1}}};

    // register map: word i at byte address 4*i
    localparam logic [2:0] ADDR_COUNT    = {REG_REACTIONS_IN_USE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = {~REG_REACTIONS_IN_USE, 2'b00};

    typedef logic [RATE_W-1:0] rate_array_t [MAX_REACTIONS];

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    cmd_t        cmd     = '0;
    logic        busy;
    logic        done;
    result_t     result;

    weighted_reaction_selector #(
        .MAX_REACTIONS (MAX_REACTIONS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bench state.
    //   rate_model / count_model : predictor's own copy of the block state,
    //                              advanced when a transaction is accepted.
    //   stim_rates               : rate table as the stimulus generator sees
    //                              it, advanced when a command is queued, so
    //                              draw points can be aimed at real intervals.
    // ------------------------------------------------------------------
    rate_array_t      rate_model  = '{default: '0};
    rate_array_t      stim_rates  = '{default: '0};
    logic [CNT_W-1:0] count_model = CNT_RESET;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    int      cmds_queued     = 0;
    int      cmds_accepted   = 0;
    int      mismatch_count  = 0;
    int      send_idle_pct   = 0;

    // Saturating sum of the first k rate entries: prefix[k] on the Q20.16 axis.
    function automatic logic [PREFIX_W-1:0] rate_prefix(rate_array_t tbl, int k);
        logic [PREFIX_W:0] acc;
        acc = '0;
        for (int i = 0; i < k; i++)
        begin
            acc = acc + tbl[i];
            if (acc > PREFIX_MAX)
                acc = PREFIX_MAX;
        end
        return acc[PREFIX_W-1:0];
    endfunction

    function automatic int entries_in_use(logic [CNT_W-1:0] cnt);
        return (cnt > MAX_REACTIONS) ? MAX_REACTIONS : int'(cnt);
    endfunction

    // Applies one accepted command to the predictor state and returns the
    // result the block must give. Selection picks the highest entry whose
    // prefix is at or below the point; prefixes never decrease, so a forward
    // scan that keeps the last hit lands past any zero-rate entries.
    function automatic result_t selection_outcome(cmd_t c);
        result_t             r;
        int                  n;
        logic [PREFIX_W-1:0] total;
        r = '0;
        if (c.operation == OP_WRITE && c.reaction_index < MAX_REACTIONS)
            rate_model[c.reaction_index] = c.rate_value;
        n     = entries_in_use(count_model);
        total = rate_prefix(rate_model, n);
        r.total_rate = total;
        if (c.operation == OP_WRITE)
            r.status = STATUS_WRITTEN;
        else if (n == 0 || c.draw_point >= total)
            r.status = STATUS_BEYOND;
        else
        begin
            r.status = STATUS_OK;
            for (int i = 0; i < n; i++)
                if (rate_prefix(rate_model, i) <= c.draw_point)
                    r.chosen_reaction = i[IDX_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued commands on start/cmd. A command is taken at an
    // edge with start high and busy low; the prediction is made right there,
    // so it sees exactly the configuration the block sees. Next values are
    // worked out first and assigned once, so start never gets two updates
    // in one step.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic offer;
        cmd_t next_cmd;
        offer    = start;
        next_cmd = cmd;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results = {expected_results, selection_outcome(cmd)};
                cmds_accepted++;
                offer = 1'b0;
            end
            if (!offer && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                offer    = 1'b1;
            end
        end
        start <= offer;
        cmd   <= next_cmd;
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a result for exactly one cycle; it is matched
    // against the oldest outstanding expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result: reaction %0d total %h status %0d",
                                          result.chosen_reaction, result.total_rate,
                                          result.status));
            else
            begin
                want = expected_results.pop_front();
                if (result.chosen_reaction !== want.chosen_reaction)
                    report_mismatch($sformatf("chosen_reaction %0d, expected %0d",
                                              result.chosen_reaction, want.chosen_reaction));
                if (result.total_rate !== want.total_rate)
                    report_mismatch($sformatf("total_rate %h, expected %h",
                                              result.total_rate, want.total_rate));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, want.status));
            end
        end
    end

    // Watchdog: any command taken, result or register write restarts the count.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable && pwrite))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Register write: setup cycle, then access cycle; written at the edge
    // where the access phase meets pready. Only word 0 exists.
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_COUNT)
            count_model = data[CNT_W-1:0];
    endtask

    task automatic queue_cmd(op_t op, logic [IDX_W-1:0] idx, logic [RATE_W-1:0] rate,
                             logic [PREFIX_W-1:0] point);
        cmd_t c;
        c.operation      = op;
        c.reaction_index = idx;
        c.rate_value     = rate;
        c.draw_point     = point;
        if (op == OP_WRITE && idx < MAX_REACTIONS)
            stim_rates[idx] = rate;
        pending_cmds = {pending_cmds, c};
        cmds_queued++;
    endtask

    // Waits until every queued command is taken and answered, then lets the
    // block settle before any register write.
    task automatic drain();
        while (cmds_accepted != cmds_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PREFIX_W-1:0] random_point();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[PREFIX_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] random_rate();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick == 2)
            return $urandom_range(255);
        return $urandom;
    endfunction

    // Random mix: about a third writes, the rest draws. Most draws land
    // inside the current total, some on or just below an interval boundary or the
    // total itself, the rest anywhere on the axis. Unused fields carry noise.
    task automatic queue_random(int items, int n_use);
        logic [PREFIX_W-1:0] total;
        logic [PREFIX_W-1:0] point;
        logic [63:0]         wide;
        int                  pick;
        for (int j = 0; j < items; j++)
        begin
            if ($urandom_range(99) < 35)
                queue_cmd(OP_WRITE, IDX_W'($urandom_range(2**IDX_W - 1)), random_rate(),
                          random_point());
            else
            begin
                total = rate_prefix(stim_rates, n_use);
                pick  = $urandom_range(9);
                wide  = {$urandom, $urandom};
                if (pick <= 5)
                    point = (total == 0) ? random_point() : PREFIX_W'(wide % total);
                else if (pick <= 7)
                    point = rate_prefix(stim_rates, int'($urandom_range(n_use)))
                            - PREFIX_W'($urandom_range(1));
                else if (pick == 8)
                    point = total - PREFIX_W'($urandom_range(1));
                else
                    point = random_point();
                queue_cmd(OP_DRAW, IDX_W'($urandom_range(2**IDX_W - 1)), $urandom, point);
            end
        end
    endtask

    // One random phase: new count (junk in the unused upper bits), new
    // sender idling, a batch of commands, then drain.
    task automatic run_phase(logic [CNT_W-1:0] count, int idle_pct, int items);
        apb_write(ADDR_COUNT, ($urandom << CNT_W) | 32'(count));
        send_idle_pct = idle_pct;
        queue_random(items, entries_in_use(count));
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [PREFIX_W-1:0] total;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset count of one, empty table: everything flagged until entry 0
        // has a rate. Full-scale rate in entry 0, draws just inside and at it.
        send_idle_pct = 0;
        queue_cmd(OP_DRAW,  4'd0,  '0, '0);
        queue_cmd(OP_WRITE, 4'd0,  '1, '0);
        queue_cmd(OP_DRAW,  4'd0,  '0, 36'h0_FFFF_FFFE);
        queue_cmd(OP_DRAW,  4'd0,  '0, 36'h0_FFFF_FFFF);
        queue_cmd(OP_WRITE, 4'd15, '1, '1);     // outside the count, total unchanged
        drain();

        // Full table, then a write to a register that does not exist.
        apb_write(ADDR_COUNT, 32'd16);
        apb_write(ADDR_UNMAPPED, 32'd3);
        queue_cmd(OP_WRITE, 4'd3, 32'h0001_0000, '0);
        queue_cmd(OP_WRITE, 4'd7, 32'd1, '0);
        queue_cmd(OP_WRITE, 4'd4, 32'h0000_8000, '0);
        queue_cmd(OP_WRITE, 4'd5, '0, '0);
        // exact hits on boundaries sitting after runs of zero-rate entries
        queue_cmd(OP_DRAW, 4'd0, '0, '0);
        queue_cmd(OP_DRAW, 4'd0, '0, rate_prefix(stim_rates, 3));
        queue_cmd(OP_DRAW, 4'd0, '0, rate_prefix(stim_rates, 5));
        total = rate_prefix(stim_rates, MAX_REACTIONS);
        queue_cmd(OP_DRAW, 4'd0, '0, total - 1'b1);
        queue_cmd(OP_DRAW, 4'd0, '0, total);
        queue_cmd(OP_DRAW, 4'd0, '0, '1);
        drain();

        // Count of zero: total is nil and every draw is flagged.
        apb_write(ADDR_COUNT, 32'd0);
        queue_cmd(OP_DRAW,  4'd0, '0, '0);
        queue_cmd(OP_WRITE, 4'd2, 32'd5, '0);
        drain();

        // Random phases: counts at and beyond the table size, zero, one and
        // a mid value; sender idling off, heavy and light.
        run_phase(5'd16, 0,  PHASE_ITEMS);
        run_phase(5'd31, 83, PHASE_ITEMS);
        run_phase(5'd0,  11, PHASE_ITEMS);
        run_phase(CNT_W'($urandom_range(2, 15)), 0, PHASE_ITEMS);
        run_phase(5'd1,  83, PHASE_ITEMS);
        run_phase(5'd17, 11, PHASE_ITEMS);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
